// ===== rtl/gcq_pkg.sv =====
// ----------------------------------------------------------------------------
// gcq_pkg
// Shared widths, codes and types of the grid cell neighbourhood query block.
// ----------------------------------------------------------------------------
package gcq_pkg;

    // field widths
    localparam int ACTION_W  = 2;
    localparam int COORD_W   = 32;
    localparam int ID_W      = 12;
    localparam int SIZE_W    = 16;
    localparam int COUNT_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // internal widths, sized for grids of up to 256 by 256 cells
    localparam int NC_W    = 9;
    localparam int BASE_W  = 16;
    localparam int LIM_W   = 24;
    localparam int NCELL_W = 17;
    localparam int NB_N    = 9;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_FIFO_DEPTH  = 4;

    // actions
    localparam logic [ACTION_W-1:0] ACT_CELL    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POS_NB  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CELL_NB = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_UNUSED  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_W   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_H   = 3'd5;

    // neighbour slots, in output order
    localparam int NB_CENTRE   = 0;
    localparam int NB_LEFT     = 1;
    localparam int NB_UP_LEFT  = 2;
    localparam int NB_DN_LEFT  = 3;
    localparam int NB_RIGHT    = 4;
    localparam int NB_UP_RIGHT = 5;
    localparam int NB_DN_RIGHT = 6;
    localparam int NB_UP       = 7;
    localparam int NB_DN       = 8;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [SIZE_W-1:0]         cell_w;
        logic [SIZE_W-1:0]         cell_h;
        logic [NC_W-1:0]           nc;
        logic [NC_W-1:0]           nr;
        logic [LIM_W-1:0]          lim_x;
        logic [LIM_W-1:0]          lim_y;
        logic [NCELL_W-1:0]        ncells;
    } t_geom;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [NB_N-1:0]   mask;
        logic              in_grid;
    } t_job;

endpackage

// ===== rtl/gcq_if.sv =====
// ----------------------------------------------------------------------------
// gcq_if
// Query, result and configuration channels of the grid cell query block.
// ----------------------------------------------------------------------------
interface gcq_query_if;
    logic                                 valid;
    logic                                 ready;
    logic [gcq_pkg::ACTION_W-1:0]         action;
    logic signed [gcq_pkg::COORD_W-1:0]   pos_x;
    logic signed [gcq_pkg::COORD_W-1:0]   pos_y;
    logic [gcq_pkg::ID_W-1:0]             query_cell;

    modport source (output valid, action, pos_x, pos_y, query_cell, input ready);
    modport sink   (input valid, action, pos_x, pos_y, query_cell, output ready);
endinterface

interface gcq_result_if;
    logic                     valid;
    logic                     ready;
    logic [gcq_pkg::ID_W-1:0] cell_id;
    logic                     in_grid;
    logic                     last;

    modport source (output valid, cell_id, in_grid, last, input ready);
    modport sink   (input valid, cell_id, in_grid, last, output ready);
endinterface

interface gcq_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gcq_pkg::CFG_IDX_W-1:0] index;
    logic [gcq_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/gcq_front.sv =====
// ----------------------------------------------------------------------------
// gcq_front
// Query pipeline: subtract origin, range check, pipelined restoring divide,
// then cell id base and neighbour mask for the emitter queue.
// ----------------------------------------------------------------------------
module gcq_front #(
    parameter int MAX_COLUMNS = gcq_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gcq_pkg::DEF_MAX_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gcq_query_if.sink            i_query,
    input  gcq_pkg::t_geom       i_geom,
    input  logic                 i_full,
    output logic                 o_push,
    output gcq_pkg::t_job        o_job
);

    localparam int CB = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int QW = (CB > RB) ? CB : RB;
    localparam int DW = gcq_pkg::SIZE_W + QW;
    localparam int DX_W = gcq_pkg::COORD_W + 1;

    logic en;

    // stage 0: accepted query
    logic                                r_v0;
    logic [gcq_pkg::ACTION_W-1:0]        r_act0;
    logic signed [gcq_pkg::COORD_W-1:0]  r_px0;
    logic signed [gcq_pkg::COORD_W-1:0]  r_py0;
    logic [gcq_pkg::ID_W-1:0]            r_q0;

    // stage 1: offsets from origin
    logic                                r_v1;
    logic [gcq_pkg::ACTION_W-1:0]        r_act1;
    logic [DX_W-1:0]                     r_dx1;
    logic [DX_W-1:0]                     r_dy1;
    logic [gcq_pkg::ID_W-1:0]            r_q1;

    // divider stages
    logic                         r_dv   [QW+1];
    logic                         r_bad  [QW+1];
    logic                         r_nb   [QW+1];
    logic                         r_byid [QW+1];
    logic [DW-1:0]                r_rx   [QW+1];
    logic [DW-1:0]                r_ry   [QW+1];
    logic [QW-1:0]                r_qx   [QW+1];
    logic [QW-1:0]                r_qy   [QW+1];
    logic [gcq_pkg::SIZE_W-1:0]   r_dvx  [QW+1];
    logic [gcq_pkg::SIZE_W-1:0]   r_dvy  [QW+1];

    // stage 3: job for the queue
    logic           r_v3;
    gcq_pkg::t_job  r_job3;

    logic bad2;
    logic is_id2;
    logic [QW-1:0] cx;
    logic [QW-1:0] cy;
    logic [gcq_pkg::BASE_W-1:0] base;
    logic has_l, has_r, has_u, has_d;
    logic [gcq_pkg::NB_N-1:0] mask;

    assign en            = !(r_v3 && i_full);
    assign i_query.ready = en;
    assign o_push        = r_v3 && !i_full;
    assign o_job         = r_job3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_dv[0] <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            // drop the unused action here: it yields nothing
            r_v0    <= i_query.valid && (i_query.action != gcq_pkg::ACT_UNUSED);
            r_v1    <= r_v0;
            r_dv[0] <= r_v1;
            r_v3    <= r_dv[QW];
        end
    end

    always_comb begin
        is_id2 = (r_act1 == gcq_pkg::ACT_CELL_NB);
        if (is_id2) begin
            bad2 = ({{(gcq_pkg::NCELL_W-gcq_pkg::ID_W){1'b0}}, r_q1} >= i_geom.ncells);
        end else begin
            bad2 = r_dx1[DX_W-1] || r_dy1[DX_W-1]
                || (r_dx1[gcq_pkg::COORD_W-1:0] >= gcq_pkg::COORD_W'(i_geom.lim_x))
                || (r_dy1[gcq_pkg::COORD_W-1:0] >= gcq_pkg::COORD_W'(i_geom.lim_y));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_act0 <= i_query.action;
            r_px0  <= i_query.pos_x;
            r_py0  <= i_query.pos_y;
            r_q0   <= i_query.query_cell;

            r_act1 <= r_act0;
            r_q1   <= r_q0;
            r_dx1  <= {r_px0[gcq_pkg::COORD_W-1], r_px0}
                    - {i_geom.origin_x[gcq_pkg::COORD_W-1], i_geom.origin_x};
            r_dy1  <= {r_py0[gcq_pkg::COORD_W-1], r_py0}
                    - {i_geom.origin_y[gcq_pkg::COORD_W-1], i_geom.origin_y};

            r_bad[0]  <= bad2;
            r_nb[0]   <= (r_act1 != gcq_pkg::ACT_CELL);
            r_byid[0] <= is_id2;
            r_rx[0]   <= r_dx1[DW-1:0];
            r_ry[0]   <= is_id2 ? DW'(r_q1) : r_dy1[DW-1:0];
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_dvx[0]  <= i_geom.cell_w;
            r_dvy[0]  <= is_id2 ? gcq_pkg::SIZE_W'(i_geom.nc) : i_geom.cell_h;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar s = 0; s < QW; s++) begin : g_div
        localparam int B = QW - 1 - s;
        logic [DW-1:0] sh_x;
        logic [DW-1:0] sh_y;
        logic          ge_x;
        logic          ge_y;

        assign sh_x = DW'(r_dvx[s]) << B;
        assign sh_y = DW'(r_dvy[s]) << B;
        assign ge_x = (r_rx[s] >= sh_x);
        assign ge_y = (r_ry[s] >= sh_y);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (en) begin
                r_dv[s+1] <= r_dv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_bad[s+1]  <= r_bad[s];
                r_nb[s+1]   <= r_nb[s];
                r_byid[s+1] <= r_byid[s];
                r_dvx[s+1]  <= r_dvx[s];
                r_dvy[s+1]  <= r_dvy[s];
                r_rx[s+1]   <= ge_x ? (r_rx[s] - sh_x) : r_rx[s];
                r_ry[s+1]   <= ge_y ? (r_ry[s] - sh_y) : r_ry[s];
                r_qx[s+1]   <= r_qx[s] | (QW'(ge_x) << B);
                r_qy[s+1]   <= r_qy[s] | (QW'(ge_y) << B);
            end
        end
    end

    always_comb begin
        // for a cell id query the column is the remainder of id / columns
        cx    = r_byid[QW] ? r_ry[QW][QW-1:0] : r_qx[QW];
        cy    = r_qy[QW];
        base  = gcq_pkg::BASE_W'(gcq_pkg::BASE_W'(cy) * gcq_pkg::BASE_W'(i_geom.nc))
              + gcq_pkg::BASE_W'(cx);
        has_l = (cx != '0);
        has_u = (cy != '0);
        has_r = ((gcq_pkg::NC_W + 1)'(cx) + 1'b1) < (gcq_pkg::NC_W + 1)'(i_geom.nc);
        has_d = ((gcq_pkg::NC_W + 1)'(cy) + 1'b1) < (gcq_pkg::NC_W + 1)'(i_geom.nr);

        mask = '0;
        mask[gcq_pkg::NB_CENTRE] = 1'b1;
        if (r_nb[QW]) begin
            mask[gcq_pkg::NB_LEFT]     = has_l;
            mask[gcq_pkg::NB_UP_LEFT]  = has_l && has_u;
            mask[gcq_pkg::NB_DN_LEFT]  = has_l && has_d;
            mask[gcq_pkg::NB_RIGHT]    = has_r;
            mask[gcq_pkg::NB_UP_RIGHT] = has_r && has_u;
            mask[gcq_pkg::NB_DN_RIGHT] = has_r && has_d;
            mask[gcq_pkg::NB_UP]       = has_u;
            mask[gcq_pkg::NB_DN]       = has_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_bad[QW]) begin
                r_job3.base    <= '0;
                r_job3.mask    <= gcq_pkg::NB_N'(1) << gcq_pkg::NB_CENTRE;
                r_job3.in_grid <= 1'b0;
            end else begin
                r_job3.base    <= base;
                r_job3.mask    <= mask;
                r_job3.in_grid <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/gcq_fifo.sv =====
// ----------------------------------------------------------------------------
// gcq_fifo
// Short job queue between the query pipeline and the result emitter.
// ----------------------------------------------------------------------------
module gcq_fifo #(
    parameter int DEPTH = gcq_pkg::DEF_FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gcq_pkg::t_job  i_job,
    input  logic           i_pop,
    output gcq_pkg::t_job  o_job,
    output logic           o_full,
    output logic           o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    gcq_pkg::t_job  r_mem [DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== rtl/gcq_back.sv =====
// ----------------------------------------------------------------------------
// gcq_back
// Result emitter: walks the neighbour mask of one job, one cell id a cycle while
// the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module gcq_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [gcq_pkg::NC_W-1:0]   i_nc,
    input  gcq_pkg::t_job              i_job,
    input  logic                       i_empty,
    output logic                       o_pop,
    gcq_result_if.source               o_result
);

    logic [gcq_pkg::NB_N-1:0]    r_mask;
    logic [gcq_pkg::BASE_W-1:0]  r_base;
    logic                        r_ing;

    logic                        r_o_valid;
    logic [gcq_pkg::ID_W-1:0]    r_o_id;
    logic                        r_o_ing;
    logic                        r_o_last;

    logic                        out_free;
    logic                        busy;
    logic [gcq_pkg::NB_N-1:0]    sel;
    logic [gcq_pkg::NB_N-1:0]    rest;
    logic                        go_up, go_dn, go_l, go_r;
    logic [gcq_pkg::BASE_W-1:0]  row_id;
    logic [gcq_pkg::BASE_W-1:0]  nb_id;
    logic                        load;

    assign o_result.valid   = r_o_valid;
    assign o_result.cell_id = r_o_id;
    assign o_result.in_grid = r_o_ing;
    assign o_result.last    = r_o_last;

    always_comb begin
        out_free = !r_o_valid || o_result.ready;
        busy     = (r_mask != '0);
        // lowest pending slot goes next
        sel      = r_mask & (~r_mask + 1'b1);
        rest     = r_mask & ~sel;

        go_up = sel[gcq_pkg::NB_UP] || sel[gcq_pkg::NB_UP_LEFT] || sel[gcq_pkg::NB_UP_RIGHT];
        go_dn = sel[gcq_pkg::NB_DN] || sel[gcq_pkg::NB_DN_LEFT] || sel[gcq_pkg::NB_DN_RIGHT];
        go_l  = sel[gcq_pkg::NB_LEFT] || sel[gcq_pkg::NB_UP_LEFT] || sel[gcq_pkg::NB_DN_LEFT];
        go_r  = sel[gcq_pkg::NB_RIGHT] || sel[gcq_pkg::NB_UP_RIGHT]
             || sel[gcq_pkg::NB_DN_RIGHT];

        if (go_up) begin
            row_id = r_base - gcq_pkg::BASE_W'(i_nc);
        end else if (go_dn) begin
            row_id = r_base + gcq_pkg::BASE_W'(i_nc);
        end else begin
            row_id = r_base;
        end

        if (go_l) begin
            nb_id = row_id - 1'b1;
        end else if (go_r) begin
            nb_id = row_id + 1'b1;
        end else begin
            nb_id = row_id;
        end

        // refill on the last result of a job so runs follow without a gap
        load  = !i_empty && (!busy || (out_free && rest == '0));
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (load) begin
                r_mask <= i_job.mask;
            end else if (busy && out_free) begin
                r_mask <= rest;
            end
            if (out_free) begin
                r_o_valid <= busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_base <= i_job.base;
            r_ing  <= i_job.in_grid;
        end
        if (busy && out_free) begin
            r_o_id   <= nb_id[gcq_pkg::ID_W-1:0];
            r_o_ing  <= r_ing;
            r_o_last <= (rest == '0);
        end
    end

endmodule

// ===== rtl/grid_cell_neighbourhood_query.sv =====
// ----------------------------------------------------------------------------
// grid_cell_neighbourhood_query
// Uniform 2D grid index with cell lookup and 3x3 neighbour query.
// ----------------------------------------------------------------------------
// Usage:
//   i_query  : valid/ready channel, one transaction per query (action, pos_x,
//              pos_y, query_cell). Action 3 is taken and yields nothing.
//   o_result : valid/ready channel, one transaction per cell id; a query gives
//              1 to 9 results, the final one with last set. A position or id
//              outside the grid gives one result with in_grid low.
//   i_cfg    : register writes (index, data), always ready; write only while
//              no query is in flight.
// Pipeline: a query passes the input, offset and divider registers, the job
//   register, the job queue, the emitter and its output register; the divide is
//   pipelined one quotient bit a stage, QW = ceil(log2(max(MAX_COLUMNS, MAX_ROWS))) bits.
// Throughput: a new query is accepted every cycle until the job queue fills;
//   the emitter then sets the pace at one result a cycle while the receiver is
//   ready, and a query gives 1 to 9 results (9 for an interior neighbourhood).
// Reset: registers return to origin 0, 1 x 1 grid, 1 x 1 cells; the pipeline,
//   queue and output are emptied. A stalled receiver holds the output; the
//   queue then fills and i_query.ready drops.
module grid_cell_neighbourhood_query #(
    parameter int MAX_COLUMNS = gcq_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = gcq_pkg::DEF_MAX_ROWS,
    parameter int FIFO_DEPTH  = gcq_pkg::DEF_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gcq_query_if.sink     i_query,
    gcq_result_if.source  o_result,
    gcq_cfg_if.sink       i_cfg
);

    logic signed [gcq_pkg::COORD_W-1:0] r_origin_x;
    logic signed [gcq_pkg::COORD_W-1:0] r_origin_y;
    logic [gcq_pkg::COUNT_W-1:0]        r_columns;
    logic [gcq_pkg::COUNT_W-1:0]        r_rows;
    logic [gcq_pkg::SIZE_W-1:0]         r_cell_w;
    logic [gcq_pkg::SIZE_W-1:0]         r_cell_h;

    logic [gcq_pkg::NC_W-1:0]    r_nc;
    logic [gcq_pkg::NC_W-1:0]    r_nr;
    logic [gcq_pkg::SIZE_W-1:0]  r_cw;
    logic [gcq_pkg::SIZE_W-1:0]  r_ch;
    logic [gcq_pkg::LIM_W-1:0]   r_lim_x;
    logic [gcq_pkg::LIM_W-1:0]   r_lim_y;
    logic [gcq_pkg::NCELL_W-1:0] r_ncells;

    logic [gcq_pkg::NC_W-1:0]    n_nc;
    logic [gcq_pkg::NC_W-1:0]    n_nr;
    logic [gcq_pkg::SIZE_W-1:0]  n_cw;
    logic [gcq_pkg::SIZE_W-1:0]  n_ch;

    gcq_pkg::t_geom w_geom;
    gcq_pkg::t_job  w_push_job;
    gcq_pkg::t_job  w_pop_job;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
            r_columns  <= gcq_pkg::COUNT_W'(1);
            r_rows     <= gcq_pkg::COUNT_W'(1);
            r_cell_w   <= gcq_pkg::SIZE_W'(1);
            r_cell_h   <= gcq_pkg::SIZE_W'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gcq_pkg::REG_ORIGIN_X: r_origin_x <= i_cfg.data;
                gcq_pkg::REG_ORIGIN_Y: r_origin_y <= i_cfg.data;
                gcq_pkg::REG_COLUMNS:  r_columns  <= i_cfg.data[gcq_pkg::COUNT_W-1:0];
                gcq_pkg::REG_ROWS:     r_rows     <= i_cfg.data[gcq_pkg::COUNT_W-1:0];
                gcq_pkg::REG_CELL_W:   r_cell_w   <= i_cfg.data[gcq_pkg::SIZE_W-1:0];
                gcq_pkg::REG_CELL_H:   r_cell_h   <= i_cfg.data[gcq_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate grid size, treat a zero cell size as one
    always_comb begin
        if (r_columns == '0) begin
            n_nc = gcq_pkg::NC_W'(1);
        end else if (gcq_pkg::NC_W'(r_columns) > gcq_pkg::NC_W'(MAX_COLUMNS)) begin
            n_nc = gcq_pkg::NC_W'(MAX_COLUMNS);
        end else begin
            n_nc = gcq_pkg::NC_W'(r_columns);
        end
        if (r_rows == '0) begin
            n_nr = gcq_pkg::NC_W'(1);
        end else if (gcq_pkg::NC_W'(r_rows) > gcq_pkg::NC_W'(MAX_ROWS)) begin
            n_nr = gcq_pkg::NC_W'(MAX_ROWS);
        end else begin
            n_nr = gcq_pkg::NC_W'(r_rows);
        end
        n_cw = (r_cell_w == '0) ? gcq_pkg::SIZE_W'(1) : r_cell_w;
        n_ch = (r_cell_h == '0) ? gcq_pkg::SIZE_W'(1) : r_cell_h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nc     <= gcq_pkg::NC_W'(1);
            r_nr     <= gcq_pkg::NC_W'(1);
            r_cw     <= gcq_pkg::SIZE_W'(1);
            r_ch     <= gcq_pkg::SIZE_W'(1);
            r_lim_x  <= gcq_pkg::LIM_W'(1);
            r_lim_y  <= gcq_pkg::LIM_W'(1);
            r_ncells <= gcq_pkg::NCELL_W'(1);
        end else begin
            r_nc     <= n_nc;
            r_nr     <= n_nr;
            r_cw     <= n_cw;
            r_ch     <= n_ch;
            r_lim_x  <= gcq_pkg::LIM_W'(gcq_pkg::LIM_W'(n_nc) * gcq_pkg::LIM_W'(n_cw));
            r_lim_y  <= gcq_pkg::LIM_W'(gcq_pkg::LIM_W'(n_nr) * gcq_pkg::LIM_W'(n_ch));
            r_ncells <= gcq_pkg::NCELL_W'(gcq_pkg::NCELL_W'(n_nc) * gcq_pkg::NCELL_W'(n_nr));
        end
    end

    assign w_geom = '{
        origin_x: r_origin_x,
        origin_y: r_origin_y,
        cell_w:   r_cw,
        cell_h:   r_ch,
        nc:       r_nc,
        nr:       r_nr,
        lim_x:    r_lim_x,
        lim_y:    r_lim_y,
        ncells:   r_ncells
    };

    gcq_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (i_query),
        .i_geom  (w_geom),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    gcq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    gcq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_nc     (r_nc),
        .i_job    (w_pop_job),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_result (o_result)
    );

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job queue read while empty");

    a_invalid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.in_grid) |-> (o_result.last && o_result.cell_id == '0))
        else $error("out-of-grid result not a single zero id");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");
`endif

endmodule
